// ----- rtl/tmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// tmtc_pkg
// Shared widths, codes and types of the tempo map tick/time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmtc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int TICK_W      = 32;
	localparam int TEMPO_W     = 24;
	localparam int TIME_W      = 48;
	localparam int TPB_W       = 15;
	localparam int FRAC_BITS   = 8;
	localparam int STATUS_W    = 3;
	localparam int REQ_W       = 2;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	// divider: 64-bit dividend, 24-bit divisor, one quotient bit a cycle
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 24;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W) + 1;

	localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};
	localparam logic [TICK_W-1:0]  TICK_MAX = {TICK_W{1'b1}};

	localparam logic [TPB_W-1:0]   TPB_RESET    = TPB_W'(480);
	localparam logic [TEMPO_W-1:0] DTEMPO_RESET = TEMPO_W'(500000);

	// register index, taken from paddr[2]
	localparam logic REG_TPB    = 1'b0;
	localparam logic REG_DTEMPO = 1'b1;

	// request codes
	localparam logic [REQ_W-1:0] REQ_APPEND    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK2TIME = 2'd2;
	localparam logic [REQ_W-1:0] REQ_TIME2TICK = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STS_FULL       = 3'd1;
	localparam logic [STATUS_W-1:0] STS_ORDER      = 3'd2;
	localparam logic [STATUS_W-1:0] STS_ZERO_TEMPO = 3'd3;
	localparam logic [STATUS_W-1:0] STS_SAT        = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RB_INIT,
		S_RB_RD,
		S_RB_LD,
		S_RB_WR,
		S_SCAN_INIT,
		S_SCAN,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_POST,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [TICK_W-1:0]  tick;
		logic [TEMPO_W-1:0] tempo;
		logic [TIME_W-1:0]  start_time;
	} entry_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/tmtc_div.sv -----
// ----------------------------------------------------------------------------
// tmtc_div
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmtc_pkg::div_req_t req,
	output tmtc_pkg::div_rsp_t     rsp
);

	logic                                run_q;
	logic                                done_q;
	logic [tmtc_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [tmtc_pkg::DIV_NUM_W-1:0]      quot_q;
	logic [tmtc_pkg::DIV_DEN_W-1:0]      rem_q;
	logic [tmtc_pkg::DIV_DEN_W-1:0]      den_q;
	logic [tmtc_pkg::DIV_DEN_W:0]        trial;
	logic [tmtc_pkg::DIV_DEN_W:0]        diff;
	logic                                ge;

	assign trial = {rem_q, quot_q[tmtc_pkg::DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= tmtc_pkg::DIV_CNT_W'(tmtc_pkg::DIV_NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - tmtc_pkg::DIV_CNT_W'(1);
				if (cnt_q == tmtc_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (run_q) begin
			// remainder stays below the divisor, so it fits its width
			rem_q  <= ge ? diff[tmtc_pkg::DIV_DEN_W-1:0] : trial[tmtc_pkg::DIV_DEN_W-1:0];
			quot_q <= {quot_q[tmtc_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

// ----- rtl/tempo_map_tick_time_convert.sv -----
// ----------------------------------------------------------------------------
// tempo_map_tick_time_convert
// Tempo map table with tick to time and time to tick conversion.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one request word: append an entry,
// clear the table, tick to time, or time to tick. Output channel
// (out_valid/out_ready) returns one result word per request, in order.
// The table (64 entries of start tick, tempo, start time) sits in one
// synchronous RAM with a registered read; start times are kept there.
// One request is worked at a time; in_ready is high only when idle.
// A clear or a rejected append needs no arithmetic; an accepted append on a
// clean table does a multiply plus a bit-serial divide for the new start
// time (on a stale table the entry is stored and timed in the rebuild).
// Conversions: linear table scan, then multiply and bit-serial divide.
// After a register write the start times are stale; the next conversion
// first rebuilds them, one divide per entry.
// A result that the receiver does not take waits in the output register;
// the next request is accepted meanwhile and finishes when it drains.
// Reset: table empty, ticks per beat 480, default tempo 500000.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_map_tick_time_convert (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tmtc_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [tmtc_pkg::DATA_W-1:0]       pwdata,
	output logic [tmtc_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [tmtc_pkg::REQ_W-1:0]        req_type,
	input  wire logic [tmtc_pkg::TEMPO_W-1:0]      tempo_value,
	input  wire logic [tmtc_pkg::TICK_W-1:0]       tick_value,
	input  wire logic [tmtc_pkg::TIME_W-1:0]       time_value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [tmtc_pkg::STATUS_W-1:0]          status,
	output logic [tmtc_pkg::TIME_W-1:0]            time_result,
	output logic [tmtc_pkg::TICK_W-1:0]            tick_result
);

	tmtc_pkg::fsm_t state_q, state_d;

	// config and control
	logic [tmtc_pkg::TPB_W-1:0]    tpb_q;
	logic [tmtc_pkg::TEMPO_W-1:0]  dtempo_q;
	logic [tmtc_pkg::CNT_W-1:0]    count_q;
	logic                          dirty_q;
	logic                          out_valid_q;
	logic                          pend_s1;
	logic                          cfg_wr;

	// request
	logic [tmtc_pkg::REQ_W-1:0]    req_q;
	logic [tmtc_pkg::TEMPO_W-1:0]  tempo_q;
	logic [tmtc_pkg::TICK_W-1:0]   tick_q;
	logic [tmtc_pkg::TIME_W-1:0]   time_q;

	// working registers
	logic [tmtc_pkg::TICK_W-1:0]   base_tick_q;
	logic [tmtc_pkg::TEMPO_W-1:0]  base_tempo_q;
	logic [tmtc_pkg::TIME_W-1:0]   base_time_q;
	logic [tmtc_pkg::TICK_W-1:0]   last_tick_q;
	logic [tmtc_pkg::TEMPO_W-1:0]  last_tempo_q;
	logic [tmtc_pkg::TIME_W-1:0]   last_time_q;
	logic [tmtc_pkg::TICK_W-1:0]   ent_tick_q;
	logic [tmtc_pkg::TEMPO_W-1:0]  ent_tempo_q;
	logic [tmtc_pkg::IDX_W-1:0]    rb_idx_q;
	logic [tmtc_pkg::CNT_W-1:0]    rd_idx_q;
	logic                          rb_q;
	logic [tmtc_pkg::DIV_NUM_W-1:0] prod_q;
	logic [tmtc_pkg::DIV_DEN_W-1:0] den_q;
	logic [tmtc_pkg::STATUS_W-1:0] res_status_q;
	logic [tmtc_pkg::TIME_W-1:0]   res_time_q;
	logic [tmtc_pkg::TICK_W-1:0]   res_tick_q;
	logic [tmtc_pkg::STATUS_W-1:0] out_status_q;
	logic [tmtc_pkg::TIME_W-1:0]   out_time_q;
	logic [tmtc_pkg::TICK_W-1:0]   out_tick_q;

	// table memory
	tmtc_pkg::entry_t              tbl_mem [tmtc_pkg::MAX_ENTRIES];
	tmtc_pkg::entry_t              rd_ent_s1;
	logic                          mem_we;
	logic [tmtc_pkg::IDX_W-1:0]    mem_waddr;
	tmtc_pkg::entry_t              mem_wdata;
	logic [tmtc_pkg::IDX_W-1:0]    mem_raddr;

	tmtc_pkg::div_req_t            div_req;
	tmtc_pkg::div_rsp_t            div_rsp;

	// combinational helpers
	logic [tmtc_pkg::TPB_W-1:0]    tpb_eff;
	logic [tmtc_pkg::TEMPO_W-1:0]  dflt_eff;
	logic                          app_full, app_order, app_zero, app_ok;
	logic                          brk, scan_issue, scan_done, rb_last, out_go;
	logic [tmtc_pkg::TICK_W-1:0]   seg_dt;
	logic [55:0]                   seg_prod;
	logic [tmtc_pkg::TIME_W-1:0]   dtime;
	logic [62:0]                   t2k_prod;
	logic                          seg_sat, add_sat, k_sat;
	logic [tmtc_pkg::TIME_W-1:0]   seg_val, add_res;
	logic [tmtc_pkg::TIME_W:0]     sum_t;
	logic [55:0]                   k_q;
	logic [56:0]                   k_sum;

	assign tpb_eff  = (tpb_q == '0) ? tmtc_pkg::TPB_W'(1) : tpb_q;
	assign dflt_eff = (dtempo_q == '0) ? tmtc_pkg::TEMPO_W'(1) : dtempo_q;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == tmtc_pkg::REG_DTEMPO)
		? tmtc_pkg::DATA_W'(dtempo_q) : tmtc_pkg::DATA_W'(tpb_q);

	// append checks, in priority order
	assign app_full  = count_q == tmtc_pkg::CNT_W'(tmtc_pkg::MAX_ENTRIES);
	assign app_order = (count_q != '0) && (tick_q < last_tick_q);
	assign app_zero  = tempo_q == '0;
	assign app_ok    = !app_full && !app_order && !app_zero;

	// scan: stop at the first entry past the request tick, or at or past the request time
	assign brk = (req_q == tmtc_pkg::REQ_TICK2TIME) ? (tick_q < rd_ent_s1.tick)
		: (time_q <= rd_ent_s1.start_time);
	assign scan_issue = rd_idx_q != count_q;
	assign scan_done  = pend_s1 ? brk : (rd_idx_q == count_q);
	assign rb_last    = (tmtc_pkg::CNT_W'(rb_idx_q) + tmtc_pkg::CNT_W'(1)) == count_q;
	assign out_go     = !out_valid_q || out_ready;

	// segment products
	assign seg_dt   = (rb_q ? ent_tick_q : tick_q) - base_tick_q;
	assign seg_prod = base_tempo_q * seg_dt;
	assign dtime    = time_q - base_time_q;
	assign t2k_prod = dtime * tpb_eff;

	// segment time from quotient, saturating add onto base time
	assign seg_sat = |div_rsp.quot[tmtc_pkg::DIV_NUM_W-1:tmtc_pkg::TIME_W];
	assign seg_val = seg_sat ? tmtc_pkg::TIME_MAX : div_rsp.quot[tmtc_pkg::TIME_W-1:0];
	assign sum_t   = {1'b0, base_time_q} + {1'b0, seg_val};
	assign add_sat = seg_sat | sum_t[tmtc_pkg::TIME_W];
	assign add_res = add_sat ? tmtc_pkg::TIME_MAX : sum_t[tmtc_pkg::TIME_W-1:0];

	// time to tick: drop the fraction bits, add base tick
	assign k_q   = div_rsp.quot[tmtc_pkg::DIV_NUM_W-1:tmtc_pkg::FRAC_BITS];
	assign k_sum = {1'b0, k_q} + 57'(base_tick_q);
	assign k_sat = |k_sum[56:tmtc_pkg::TICK_W];

	assign div_req.start = state_q == tmtc_pkg::S_DIVGO;
	assign div_req.num   = prod_q;
	assign div_req.den   = den_q;

	tmtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmtc_pkg::S_IDLE: begin
				if (in_valid) state_d = tmtc_pkg::S_DISPATCH;
			end
			tmtc_pkg::S_DISPATCH: begin
				case (req_q)
					tmtc_pkg::REQ_APPEND: begin
						state_d = (app_ok && !dirty_q) ? tmtc_pkg::S_MUL : tmtc_pkg::S_DONE;
					end
					tmtc_pkg::REQ_CLEAR: state_d = tmtc_pkg::S_DONE;
					default: begin
						state_d = dirty_q ? tmtc_pkg::S_RB_INIT : tmtc_pkg::S_SCAN_INIT;
					end
				endcase
			end
			tmtc_pkg::S_RB_INIT: begin
				state_d = (count_q == '0) ? tmtc_pkg::S_SCAN_INIT : tmtc_pkg::S_RB_RD;
			end
			tmtc_pkg::S_RB_RD:   state_d = tmtc_pkg::S_RB_LD;
			tmtc_pkg::S_RB_LD:   state_d = tmtc_pkg::S_MUL;
			tmtc_pkg::S_MUL:     state_d = tmtc_pkg::S_DIVGO;
			tmtc_pkg::S_DIVGO:   state_d = tmtc_pkg::S_DIV;
			tmtc_pkg::S_DIV: begin
				if (div_rsp.done) state_d = rb_q ? tmtc_pkg::S_RB_WR : tmtc_pkg::S_POST;
			end
			tmtc_pkg::S_RB_WR: begin
				state_d = rb_last ? tmtc_pkg::S_SCAN_INIT : tmtc_pkg::S_RB_RD;
			end
			tmtc_pkg::S_SCAN_INIT: state_d = tmtc_pkg::S_SCAN;
			tmtc_pkg::S_SCAN: begin
				if (scan_done) state_d = tmtc_pkg::S_MUL;
			end
			tmtc_pkg::S_POST: state_d = tmtc_pkg::S_DONE;
			tmtc_pkg::S_DONE: begin
				if (out_go) state_d = tmtc_pkg::S_IDLE;
			end
			default: state_d = tmtc_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[tmtc_pkg::IDX_W-1:0];
		mem_wdata = '{tick: tick_q, tempo: tempo_q, start_time: add_res};
		mem_raddr = rb_idx_q;
		case (state_q)
			tmtc_pkg::S_IDLE: in_ready = 1'b1;
			tmtc_pkg::S_DISPATCH: begin
				// stale table: store the entry, its time comes with the rebuild
				mem_we    = (req_q == tmtc_pkg::REQ_APPEND) && app_ok && dirty_q;
				mem_wdata = '{tick: tick_q, tempo: tempo_q, start_time: '0};
			end
			tmtc_pkg::S_POST: mem_we = req_q == tmtc_pkg::REQ_APPEND;
			tmtc_pkg::S_RB_WR: begin
				mem_we    = 1'b1;
				mem_waddr = rb_idx_q;
				mem_wdata = '{tick: ent_tick_q, tempo: ent_tempo_q, start_time: add_res};
			end
			tmtc_pkg::S_SCAN: mem_raddr = rd_idx_q[tmtc_pkg::IDX_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) tbl_mem[mem_waddr] <= mem_wdata;
		rd_ent_s1 <= tbl_mem[mem_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmtc_pkg::S_IDLE;
			tpb_q       <= tmtc_pkg::TPB_RESET;
			dtempo_q    <= tmtc_pkg::DTEMPO_RESET;
			count_q     <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == tmtc_pkg::S_SCAN) && scan_issue;
			if (cfg_wr) begin
				if (paddr[2] == tmtc_pkg::REG_DTEMPO) dtempo_q <= pwdata[tmtc_pkg::TEMPO_W-1:0];
				else tpb_q <= pwdata[tmtc_pkg::TPB_W-1:0];
				dirty_q <= 1'b1;
			end else begin
				case (state_q)
					tmtc_pkg::S_DISPATCH: begin
						if (req_q == tmtc_pkg::REQ_CLEAR) begin
							count_q <= '0;
							dirty_q <= 1'b0;
						end else if (req_q == tmtc_pkg::REQ_APPEND && app_ok && dirty_q) begin
							count_q <= count_q + tmtc_pkg::CNT_W'(1);
						end
					end
					tmtc_pkg::S_RB_INIT: begin
						if (count_q == '0) dirty_q <= 1'b0;
					end
					tmtc_pkg::S_RB_WR: begin
						if (rb_last) dirty_q <= 1'b0;
					end
					tmtc_pkg::S_POST: begin
						if (req_q == tmtc_pkg::REQ_APPEND) count_q <= count_q + tmtc_pkg::CNT_W'(1);
					end
					default: ;
				endcase
			end
			if (state_q == tmtc_pkg::S_DONE && out_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tmtc_pkg::S_IDLE: begin
				if (in_valid) begin
					req_q   <= req_type;
					tempo_q <= tempo_value;
					tick_q  <= tick_value;
					time_q  <= time_value;
				end
			end
			tmtc_pkg::S_DISPATCH: begin
				res_status_q <= tmtc_pkg::STS_OK;
				res_time_q   <= '0;
				res_tick_q   <= '0;
				rb_q         <= 1'b0;
				if (req_q == tmtc_pkg::REQ_APPEND) begin
					if (app_full)       res_status_q <= tmtc_pkg::STS_FULL;
					else if (app_order) res_status_q <= tmtc_pkg::STS_ORDER;
					else if (app_zero)  res_status_q <= tmtc_pkg::STS_ZERO_TEMPO;
					else begin
						last_tick_q  <= tick_q;
						last_tempo_q <= tempo_q;
					end
					// new segment starts where the last entry (or tick 0) left off
					if (count_q != '0) begin
						base_tick_q  <= last_tick_q;
						base_tempo_q <= last_tempo_q;
						base_time_q  <= last_time_q;
					end else begin
						base_tick_q  <= '0;
						base_tempo_q <= dflt_eff;
						base_time_q  <= '0;
					end
				end
			end
			tmtc_pkg::S_RB_INIT: begin
				base_tick_q  <= '0;
				base_tempo_q <= dflt_eff;
				base_time_q  <= '0;
				rb_idx_q     <= '0;
				rb_q         <= 1'b1;
			end
			tmtc_pkg::S_RB_LD: begin
				ent_tick_q  <= rd_ent_s1.tick;
				ent_tempo_q <= rd_ent_s1.tempo;
			end
			tmtc_pkg::S_MUL: begin
				if (!rb_q && req_q == tmtc_pkg::REQ_TIME2TICK) begin
					prod_q <= {1'b0, t2k_prod};
					den_q  <= base_tempo_q;
				end else begin
					prod_q <= {seg_prod, tmtc_pkg::FRAC_BITS'(0)};
					den_q  <= tmtc_pkg::DIV_DEN_W'(tpb_eff);
				end
			end
			tmtc_pkg::S_RB_WR: begin
				base_time_q  <= add_res;
				base_tick_q  <= ent_tick_q;
				base_tempo_q <= ent_tempo_q;
				rb_idx_q     <= rb_idx_q + tmtc_pkg::IDX_W'(1);
				if (rb_last) last_time_q <= add_res;
			end
			tmtc_pkg::S_SCAN_INIT: begin
				base_tick_q  <= '0;
				base_tempo_q <= dflt_eff;
				base_time_q  <= '0;
				rd_idx_q     <= '0;
				rb_q         <= 1'b0;
			end
			tmtc_pkg::S_SCAN: begin
				if (scan_issue) rd_idx_q <= rd_idx_q + tmtc_pkg::CNT_W'(1);
				if (pend_s1 && !brk) begin
					base_tick_q  <= rd_ent_s1.tick;
					base_tempo_q <= rd_ent_s1.tempo;
					base_time_q  <= rd_ent_s1.start_time;
				end
			end
			tmtc_pkg::S_POST: begin
				case (req_q)
					tmtc_pkg::REQ_APPEND: last_time_q <= add_res;
					tmtc_pkg::REQ_TICK2TIME: begin
						res_time_q <= add_res;
						if (add_sat || base_time_q == tmtc_pkg::TIME_MAX)
							res_status_q <= tmtc_pkg::STS_SAT;
					end
					tmtc_pkg::REQ_TIME2TICK: begin
						res_tick_q <= k_sat ? tmtc_pkg::TICK_MAX : k_sum[tmtc_pkg::TICK_W-1:0];
						if (k_sat) res_status_q <= tmtc_pkg::STS_SAT;
					end
					default: ;
				endcase
			end
			tmtc_pkg::S_DONE: begin
				if (out_go) begin
					out_status_q <= res_status_q;
					out_time_q   <= res_time_q;
					out_tick_q   <= res_tick_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign time_result = out_time_q;
	assign tick_result = out_tick_q;

endmodule

`default_nettype wire
